FILE: hw/rtl/rrs_pkg.sv
// Shared types and constants for the rounded rectangle pixel shader.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package rrs_pkg;

  // Framebuffer defaults
  localparam int unsigned FB_WIDTH_DEF  = 1024;
  localparam int unsigned FB_HEIGHT_DEF = 1024;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Field widths
  localparam int unsigned POS_W     = 13;  // rect_x/y/w/h
  localparam int unsigned PIX_W     = 12;  // pix_col, pix_row
  localparam int unsigned RAD_W     = 10;  // corner_radius, feather_width
  localparam int unsigned ADDR_W    = 20;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned ALPHA_W   = 8;
  localparam int unsigned ALPHA_LSB = 24;

  // Distance datapath
  localparam int unsigned DX_W       = 14;                          // signed corner offset
  localparam int unsigned D2_W       = 27;                          // dx^2 + dy^2
  localparam int unsigned FRAC_SHIFT = 16;                          // times 65536
  localparam int unsigned ROOT_W     = (D2_W + FRAC_SHIFT + 1) / 2; // distance in 1/256 px
  localparam int unsigned N_W        = 2 * ROOT_W;                  // radicand
  localparam int unsigned REM_W      = ROOT_W + 2;

  // Fade datapath
  localparam int unsigned SUB_BITS = 8;                // 1/256 pixel
  localparam int unsigned NUM_W    = RAD_W + SUB_BITS; // radius or feather times 256
  localparam int unsigned LIM_W    = NUM_W + 1;        // radius plus feather
  localparam int unsigned PROD_W   = NUM_W + ALPHA_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_X        = 3'd0,
    REG_RECT_Y        = 3'd1,
    REG_RECT_W        = 3'd2,
    REG_RECT_H        = 3'd3,
    REG_CORNER_RADIUS = 3'd4,
    REG_FEATHER_WIDTH = 3'd5,
    REG_FILL_COLOR    = 3'd6
  } rrs_reg_e;

  typedef enum logic [2:0] {
    SHADE_FILL  = 3'b001,
    SHADE_CLEAR = 3'b010,
    SHADE_FADE  = 3'b100
  } rrs_shade_e;

  typedef struct packed {
    logic signed [POS_W-1:0] rect_x;
    logic signed [POS_W-1:0] rect_y;
    logic [POS_W-1:0]        rect_w;
    logic [POS_W-1:0]        rect_h;
    logic [RAD_W-1:0]        corner_radius;
    logic [RAD_W-1:0]        feather_width;
    logic [COLOR_W-1:0]      fill_color;
  } rrs_cfg_t;

  // Per-pixel data that rides alongside the distance computation
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              in_corner;
  } rrs_side_t;

  typedef struct packed {
    logic            valid;
    logic [D2_W-1:0] d2;
    rrs_side_t       side;
  } rrs_dist_req_t;

  typedef struct packed {
    logic              valid;
    logic [ROOT_W-1:0] root;
    rrs_side_t         side;
  } rrs_root_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rrs_pix_in_if.sv
// Pixel request channel into the shader: valid/ready plus rectangle-relative position.
// Depends on rrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rrs_pix_in_if
  import rrs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pix_col;
  logic [PIX_W-1:0] pix_row;

  modport source (output valid, output pix_col, output pix_row, input ready);
  modport sink   (input valid, input pix_col, input pix_row, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rrs_pix_out_if.sv
// Shaded pixel channel out of the shader: valid/ready plus address and ARGB value.
// Depends on rrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rrs_pix_out_if
  import rrs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] pixel_color;

  modport source (output valid, output pixel_address, output pixel_color, input ready);
  modport sink   (input valid, input pixel_address, input pixel_color, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rrs_front.sv
// Front end: clipping, address, corner selection and squared corner distance.
// Four register stages; depends on rrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrs_front
  import rrs_pkg::*;
#(
  parameter int unsigned FB_WIDTH  = FB_WIDTH_DEF,
  parameter int unsigned FB_HEIGHT = FB_HEIGHT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             in_valid_i,
  input  logic [PIX_W-1:0] pix_col_i,
  input  logic [PIX_W-1:0] pix_row_i,
  input  rrs_cfg_t         cfg_i,
  output rrs_dist_req_t    dist_o
);

  localparam logic signed [DX_W-1:0] FB_COL_LIM = DX_W'(FB_WIDTH);
  localparam logic signed [DX_W-1:0] FB_ROW_LIM = DX_W'(FB_HEIGHT);
  localparam int unsigned AMUL_W = 2 * PIX_W + 1;

  // Stage 1: clip, corner flags
  logic signed [DX_W-1:0] px, py;
  logic [POS_W-1:0] col_x, row_x, rad_x;
  logic inside_rect, inside_fb, left, right, top, bottom;
  logic s1_v_d, s1_corner_d, s1_cxr_d, s1_cyb_d;

  logic             s1_v_q, s1_corner_q, s1_cxr_q, s1_cyb_q;
  logic [PIX_W-1:0] s1_col_q, s1_row_q, s1_px_q, s1_py_q;

  always_comb begin
    col_x = {1'b0, pix_col_i};
    row_x = {1'b0, pix_row_i};
    rad_x = POS_W'(cfg_i.corner_radius);
    px = {cfg_i.rect_x[POS_W-1], cfg_i.rect_x} + {2'b00, pix_col_i};
    py = {cfg_i.rect_y[POS_W-1], cfg_i.rect_y} + {2'b00, pix_row_i};
    inside_rect = (col_x < cfg_i.rect_w) && (row_x < cfg_i.rect_h);
    inside_fb = !px[DX_W-1] && !py[DX_W-1] && (px < FB_COL_LIM) && (py < FB_ROW_LIM);
    s1_v_d = in_valid_i && inside_rect && inside_fb;

    left   = col_x < rad_x;
    right  = (col_x + rad_x) >= cfg_i.rect_w;
    top    = row_x < rad_x;
    bottom = (row_x + rad_x) >= cfg_i.rect_h;

    s1_corner_d = 1'b1;
    s1_cxr_d    = 1'b0;
    s1_cyb_d    = 1'b0;
    // first matching corner wins where corners overlap
    priority if (cfg_i.corner_radius == '0) begin
      s1_corner_d = 1'b0;
    end else if (left && top) begin
      s1_cxr_d = 1'b0;
    end else if (right && top) begin
      s1_cxr_d = 1'b1;
    end else if (left && bottom) begin
      s1_cyb_d = 1'b1;
    end else if (right && bottom) begin
      s1_cxr_d = 1'b1;
      s1_cyb_d = 1'b1;
    end else begin
      s1_corner_d = 1'b0;
    end
  end

  // Stage 2: corner offsets and framebuffer address
  logic signed [DX_W-1:0] s2_dx_d, s2_dy_d;
  logic [AMUL_W-1:0] addr_full;
  rrs_side_t s2_side_d;

  logic                   s2_v_q;
  logic signed [DX_W-1:0] s2_dx_q, s2_dy_q;
  rrs_side_t              s2_side_q;

  always_comb begin
    s2_dx_d = s1_cxr_q
      ? ({2'b00, s1_col_q} + DX_W'(cfg_i.corner_radius) - {1'b0, cfg_i.rect_w})
      : ({2'b00, s1_col_q} - DX_W'(cfg_i.corner_radius));
    s2_dy_d = s1_cyb_q
      ? ({2'b00, s1_row_q} + DX_W'(cfg_i.corner_radius) - {1'b0, cfg_i.rect_h})
      : ({2'b00, s1_row_q} - DX_W'(cfg_i.corner_radius));
    addr_full = AMUL_W'(s1_py_q) * AMUL_W'(FB_WIDTH) + AMUL_W'(s1_px_q);
    s2_side_d.addr      = addr_full[ADDR_W-1:0];
    s2_side_d.in_corner = s1_corner_q;
  end

  // Stage 3: squares
  logic signed [2*DX_W-1:0] sqx_full, sqy_full;
  logic                  s3_v_q;
  logic [D2_W-2:0]       s3_sqx_q, s3_sqy_q;
  rrs_side_t             s3_side_q;

  assign sqx_full = s2_dx_q * s2_dx_q;
  assign sqy_full = s2_dy_q * s2_dy_q;

  // Stage 4: sum
  logic            s4_v_q;
  logic [D2_W-1:0] s4_d2_q;
  rrs_side_t       s4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_col_q    <= pix_col_i;
      s1_row_q    <= pix_row_i;
      s1_px_q     <= px[PIX_W-1:0];
      s1_py_q     <= py[PIX_W-1:0];
      s1_corner_q <= s1_corner_d;
      s1_cxr_q    <= s1_cxr_d;
      s1_cyb_q    <= s1_cyb_d;
      s2_dx_q     <= s2_dx_d;
      s2_dy_q     <= s2_dy_d;
      s2_side_q   <= s2_side_d;
      s3_sqx_q    <= sqx_full[D2_W-2:0];
      s3_sqy_q    <= sqy_full[D2_W-2:0];
      s3_side_q   <= s2_side_q;
      s4_d2_q     <= {1'b0, s3_sqx_q} + {1'b0, s3_sqy_q};
      s4_side_q   <= s3_side_q;
    end
  end

  assign dist_o.valid = s4_v_q;
  assign dist_o.d2    = s4_d2_q;
  assign dist_o.side  = s4_side_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rrs_sqrt.sv
// Pipelined floor square root of d2 * 65536, one result bit per stage.
// Depends on rrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrs_sqrt
  import rrs_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  rrs_dist_req_t dist_i,
  output rrs_root_req_t root_o
);

  logic [ROOT_W-1:0] v_q;
  logic [D2_W-1:0]   d2_q   [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  rrs_side_t         side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_in;
    logic [D2_W-1:0]   d2_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    rrs_side_t         side_in;
    logic [N_W-1:0]    radicand;
    logic [REM_W-1:0]  rem_sh, trial, rem_d;
    logic [ROOT_W-1:0] root_d;

    if (k == 0) begin : g_first
      assign v_in    = dist_i.valid;
      assign d2_in   = dist_i.d2;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = dist_i.side;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign d2_in   = d2_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      radicand = N_W'({d2_in, {FRAC_SHIFT{1'b0}}});
      // bring down the next two radicand bits, try root*4+1
      rem_sh = {rem_in[REM_W-3:0], radicand[N_W-1-2*k -: 2]};
      trial  = {root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d2_q[k]   <= d2_in;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign root_o.valid = v_q[ROOT_W-1];
  assign root_o.root  = root_q[ROOT_W-1];
  assign root_o.side  = side_q[ROOT_W-1];

  // Assertions
  localparam int unsigned SQ_W = N_W + 2;
  logic [N_W-1:0] radicand_out;
  assign radicand_out = N_W'({d2_q[ROOT_W-1], {FRAC_SHIFT{1'b0}}});

  a_root_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_o.valid |->
      (SQ_W'(root_o.root) * SQ_W'(root_o.root) <= SQ_W'(radicand_out)) &&
      (SQ_W'(radicand_out) <
       (SQ_W'(root_o.root) + SQ_W'(1)) * (SQ_W'(root_o.root) + SQ_W'(1))))
    else $error("square root stage result is not the floor root");

endmodule

`default_nettype wire

FILE: hw/rtl/rrs_fade.sv
// Shade selection, alpha scaling and pipelined alpha division, then the output register.
// Depends on rrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrs_fade
  import rrs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  rrs_root_req_t      root_i,
  input  rrs_cfg_t           cfg_i,
  output logic               out_valid_o,
  output logic [ADDR_W-1:0]  out_addr_o,
  output logic [COLOR_W-1:0] out_color_o
);

  logic [ALPHA_W-1:0] fill_alpha;
  assign fill_alpha = cfg_i.fill_color[COLOR_W-1:ALPHA_LSB];

  // F1: classify against radius and radius plus feather
  logic [NUM_W-1:0] r256, f256;
  logic [LIM_W-1:0] lim, lim_gap;
  rrs_shade_e       f1_mode_d;

  logic              f1_v_q;
  rrs_shade_e        f1_mode_q;
  logic [NUM_W-1:0]  f1_num_q;
  logic [ADDR_W-1:0] f1_addr_q;

  always_comb begin
    r256    = {cfg_i.corner_radius, {SUB_BITS{1'b0}}};
    f256    = {cfg_i.feather_width, {SUB_BITS{1'b0}}};
    lim     = {1'b0, r256} + {1'b0, f256};
    lim_gap = lim - root_i.root[LIM_W-1:0];
    priority if (!root_i.side.in_corner) begin
      f1_mode_d = SHADE_FILL;
    end else if (root_i.root >= ROOT_W'(lim)) begin
      f1_mode_d = SHADE_CLEAR;
    end else if (root_i.root <= ROOT_W'(r256)) begin
      f1_mode_d = SHADE_FILL;
    end else begin
      f1_mode_d = SHADE_FADE;
    end
  end

  // F2: scale by fill alpha; drop the 1/256 scale from the dividend
  logic [PROD_W-1:0] prod;
  logic              f2_v_q;
  rrs_shade_e        f2_mode_q;
  logic [NUM_W-1:0]  f2_num_q;
  logic [ADDR_W-1:0] f2_addr_q;

  assign prod = PROD_W'(f1_num_q) * PROD_W'(fill_alpha);

  // Divider: one quotient bit per stage, divisor is the feather width
  logic [ALPHA_W-1:0] dv_q;
  rrs_shade_e         dmode_q [ALPHA_W];
  logic [NUM_W-1:0]   drem_q  [ALPHA_W];
  logic [ALPHA_W-1:0] dquo_q  [ALPHA_W];
  logic [ADDR_W-1:0]  daddr_q [ALPHA_W];

  for (genvar j = 0; j < ALPHA_W; j++) begin : g_div
    localparam int unsigned BIT = ALPHA_W - 1 - j;
    logic               v_in;
    rrs_shade_e         mode_in;
    logic [NUM_W-1:0]   rem_in, trial, rem_d;
    logic [ALPHA_W-1:0] quo_in, quo_d;
    logic [ADDR_W-1:0]  addr_in;

    if (j == 0) begin : g_first
      assign v_in    = f2_v_q;
      assign mode_in = f2_mode_q;
      assign rem_in  = f2_num_q;
      assign quo_in  = '0;
      assign addr_in = f2_addr_q;
    end else begin : g_next
      assign v_in    = dv_q[j-1];
      assign mode_in = dmode_q[j-1];
      assign rem_in  = drem_q[j-1];
      assign quo_in  = dquo_q[j-1];
      assign addr_in = daddr_q[j-1];
    end

    always_comb begin
      trial = NUM_W'(cfg_i.feather_width) << BIT;
      quo_d = quo_in;
      if (rem_in >= trial) begin
        rem_d      = rem_in - trial;
        quo_d[BIT] = 1'b1;
      end else begin
        rem_d = rem_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (en_i) begin
        dv_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dmode_q[j] <= mode_in;
        drem_q[j]  <= rem_d;
        dquo_q[j]  <= quo_d;
        daddr_q[j] <= addr_in;
      end
    end
  end

  // Output register
  logic [COLOR_W-1:0] color_d;
  logic               out_v_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [COLOR_W-1:0] out_color_q;

  always_comb begin
    unique case (dmode_q[ALPHA_W-1])
      SHADE_FILL:  color_d = cfg_i.fill_color;
      SHADE_CLEAR: color_d = '0;
      SHADE_FADE:  color_d = {dquo_q[ALPHA_W-1], cfg_i.fill_color[ALPHA_LSB-1:0]};
      default:     color_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q  <= 1'b0;
      f2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      f1_v_q  <= root_i.valid;
      f2_v_q  <= f1_v_q;
      out_v_q <= dv_q[ALPHA_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_mode_q   <= f1_mode_d;
      f1_num_q    <= lim_gap[NUM_W-1:0];
      f1_addr_q   <= root_i.side.addr;
      f2_mode_q   <= f1_mode_q;
      f2_num_q    <= prod[PROD_W-1:SUB_BITS];
      f2_addr_q   <= f1_addr_q;
      out_addr_q  <= daddr_q[ALPHA_W-1];
      out_color_q <= color_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_addr_o  = out_addr_q;
  assign out_color_o = out_color_q;

  // Assertions
  a_div_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_q[ALPHA_W-1] && dmode_q[ALPHA_W-1] == SHADE_FADE) |->
      (drem_q[ALPHA_W-1] < NUM_W'(cfg_i.feather_width)) &&
      (dquo_q[ALPHA_W-1] <= fill_alpha))
    else $error("fade divider left a remainder at or above the feather width");

endmodule

`default_nettype wire

FILE: hw/rtl/rounded_rect_pixel_shader.sv
// Rounded rectangle pixel shader, top level: config registers, stall control, pipeline.
// Register stages from request accept to result valid: 4 front, 22 root, 11 fade/out.
// Throughput: one pixel request per clock while no result is held; the root and divider stages are fully pipelined.
// A held result freezes every stage at once; nothing in flight is lost or repeated.
// Reset (rst_ni low, asynchronous): config registers and all valid flags zero, pipeline empty.
// Depends on rrs_pkg, rrs_pix_in_if, rrs_pix_out_if, rrs_front, rrs_sqrt, rrs_fade.
`timescale 1ns / 1ps
`default_nettype none

module rounded_rect_pixel_shader
  import rrs_pkg::*;
#(
  parameter int unsigned FB_WIDTH  = FB_WIDTH_DEF,
  parameter int unsigned FB_HEIGHT = FB_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  rrs_pix_in_if.sink            pix_in,
  rrs_pix_out_if.source         pix_out
);

  // Configuration registers; writes to unknown indexes drop silently
  rrs_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (rrs_reg_e'(cfg_idx_i))
        REG_RECT_X:        cfg_q.rect_x        <= cfg_wdata_i[POS_W-1:0];
        REG_RECT_Y:        cfg_q.rect_y        <= cfg_wdata_i[POS_W-1:0];
        REG_RECT_W:        cfg_q.rect_w        <= cfg_wdata_i[POS_W-1:0];
        REG_RECT_H:        cfg_q.rect_h        <= cfg_wdata_i[POS_W-1:0];
        REG_CORNER_RADIUS: cfg_q.corner_radius <= cfg_wdata_i[RAD_W-1:0];
        REG_FEATHER_WIDTH: cfg_q.feather_width <= cfg_wdata_i[RAD_W-1:0];
        REG_FILL_COLOR:    cfg_q.fill_color    <= cfg_wdata_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline whenever the output register is free or drains
  logic en;
  logic out_valid;
  assign en = !out_valid || pix_out.ready;

  // Accept a request whenever the pipeline advances
  assign pix_in.ready = en;

  rrs_dist_req_t dist_req;
  rrs_root_req_t root_req;

  // Clip, address, corner select and squared distance
  rrs_front #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (pix_in.valid),
    .pix_col_i  (pix_in.pix_col),
    .pix_row_i  (pix_in.pix_row),
    .cfg_i      (cfg_q),
    .dist_o     (dist_req)
  );

  // Distance in 1/256 pixel
  rrs_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .dist_i (dist_req),
    .root_o (root_req)
  );

  // Fill, clear or fade, then hold in the output register
  rrs_fade u_fade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .root_i      (root_req),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid),
    .out_addr_o  (pix_out.pixel_address),
    .out_color_o (pix_out.pixel_color)
  );

  assign pix_out.valid = out_valid;

  // Assertions
  a_out_rise_on_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(en))
    else $error("result appeared while the pipeline was stalled");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> pix_in.ready)
    else $error("input stalled with an empty output register");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !pix_out.ready) |=>
      (out_valid && $stable(pix_out.pixel_address) && $stable(pix_out.pixel_color)))
    else $error("held result changed before it was taken");

endmodule

`default_nettype wire

FILE: tb/sv/rounded_rect_pixel_shader_tb.sv
// Self-checking testbench for rounded_rect_pixel_shader: directed corner, fade, clip
// and register cases, then randomized shapes and pixel streams with random flow control.
// Depends on rrs_pkg, rrs_pix_in_if, rrs_pix_out_if and the shader RTL.
`timescale 1ns / 1ps

module rounded_rect_pixel_shader_tb;
  import rrs_pkg::*;

  localparam int          FB_W          = FB_WIDTH_DEF;
  localparam int          FB_H          = FB_HEIGHT_DEF;
  localparam int          RESET_CYCLES  = 7;
  // Pipeline is 37 deep; give requests that produce nothing time to leave it.
  localparam int          DRAIN_CYCLES  = 60;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          RAND_ITEMS    = 400;
  localparam int          PHASE_KEPT    = 50;
  localparam int          PHASE_TRIES   = 150;
  localparam int          MAX_PHASES    = 16;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // Index 7 maps to no register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  typedef struct {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
  } pix_req_t;

  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] argb;
  } shaded_px_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  rrs_pix_in_if  pix_in_bus ();
  rrs_pix_out_if pix_out_bus ();

  rounded_rect_pixel_shader uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_in      (pix_in_bus),
    .pix_out     (pix_out_bus)
  );

  // Testbench copy of the register file; only changes while the shader is idle.
  rrs_cfg_t    shape;
  pix_req_t    pending_px_q[$];
  shaded_px_t  shaded_q[$];
  int          fail_cnt = 0;
  int unsigned cycle_cnt;
  int unsigned hold_req = 0;
  logic        rx_hold;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Floor square root, bit by bit from the top; radicand stays well below 2^48.
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned acc;
    longint unsigned trial;
    acc = 0;
    for (int b = 24; b >= 0; b--) begin
      trial = acc | (64'd1 << b);
      if (trial * trial <= n) acc = trial;
    end
    return acc;
  endfunction

  // Work out the pixel the shader should emit for one request. Returns 0 when the
  // request is clipped by the rectangle or the framebuffer and nothing comes out.
  function automatic bit shade_pixel(input rrs_cfg_t s, input logic [PIX_W-1:0] col_in,
                                     input logic [PIX_W-1:0] row_in, output shaded_px_t px);
    longint c, rw, w, h, rad, px_x, px_y, cx, cy, dx, dy;
    longint dist256, r256, f256, delta, alpha;
    bit     corner;
    c      = col_in;
    rw     = row_in;
    w      = s.rect_w;
    h      = s.rect_h;
    rad    = s.corner_radius;
    corner = 1'b0;
    cx     = 0;
    cy     = 0;
    px.addr = '0;
    px.argb = '0;
    if (c >= w || rw >= h) return 1'b0;
    px_x = longint'($signed(s.rect_x)) + c;
    px_y = longint'($signed(s.rect_y)) + rw;
    if (px_x < 0 || px_y < 0 || px_x >= FB_W || px_y >= FB_H) return 1'b0;

    // First matching corner wins: top-left, top-right, bottom-left, bottom-right.
    if (rad > 0) begin
      if (c < rad && rw < rad) begin
        cx = rad; cy = rad; corner = 1'b1;
      end else if (c >= w - rad && rw < rad) begin
        cx = w - rad; cy = rad; corner = 1'b1;
      end else if (c < rad && rw >= h - rad) begin
        cx = rad; cy = h - rad; corner = 1'b1;
      end else if (c >= w - rad && rw >= h - rad) begin
        cx = w - rad; cy = h - rad; corner = 1'b1;
      end
    end

    px.argb = s.fill_color;
    if (corner) begin
      dx      = c - cx;
      dy      = rw - cy;
      dist256 = longint'(root_floor(longint'(dx * dx + dy * dy) << FRAC_SHIFT));
      r256    = rad << SUB_BITS;
      f256    = longint'(s.feather_width) << SUB_BITS;
      delta   = dist256 - r256;
      if (delta >= f256) begin
        px.argb = '0;
      end else if (delta > 0) begin
        alpha   = ((f256 - delta) * longint'(s.fill_color[COLOR_W-1:ALPHA_LSB])) / f256;
        px.argb = {alpha[ALPHA_W-1:0], s.fill_color[ALPHA_LSB-1:0]};
      end
    end
    px.addr = ADDR_W'(px_y * FB_W + px_x);
    return 1'b1;
  endfunction

  // Idle length for either side: mostly none or short, now and then long, and
  // occasional bursts with no idling at all.
  function automatic int unsigned pick_gap(inout int unsigned burst_left);
    int unsigned roll;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Request driver: offer the head of the pending queue, hold it until taken,
  // then predict its result and idle for a random gap.
  always @(posedge clk_i or negedge rst_ni) begin : px_driver
    int unsigned tx_gap;
    int unsigned tx_burst;
    shaded_px_t  want;
    if (!rst_ni) begin
      pix_in_bus.valid   <= 1'b0;
      pix_in_bus.pix_col <= '0;
      pix_in_bus.pix_row <= '0;
      tx_gap   = 0;
      tx_burst = 0;
    end else begin
      if (pix_in_bus.valid && pix_in_bus.ready) begin
        if (shade_pixel(shape, pix_in_bus.pix_col, pix_in_bus.pix_row, want))
          shaded_q.push_back(want);
        void'(pending_px_q.pop_front());
        tx_gap = pick_gap(tx_burst);
      end
      if (tx_gap != 0 || pending_px_q.size() == 0) begin
        pix_in_bus.valid <= 1'b0;
      end else begin
        pix_in_bus.valid   <= 1'b1;
        pix_in_bus.pix_col <= pending_px_q[0].col;
        pix_in_bus.pix_row <= pending_px_q[0].row;
      end
      if (tx_gap != 0) tx_gap--;
    end
  end

  // Long receiver hold-off: each new hold request drops ready for HOLD_CYCLES
  // while the driver keeps offering, so the pipeline fills and back-pressures.
  always @(posedge clk_i or negedge rst_ni) begin : rx_holdoff
    int unsigned hold_left;
    int unsigned hold_seen;
    if (!rst_ni) begin
      rx_hold   <= 1'b0;
      hold_left = 0;
      hold_seen = 0;
    end else if (hold_left != 0) begin
      hold_left--;
      rx_hold <= (hold_left != 0);
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      rx_hold <= 1'b1;
    end
  end

  // Result monitor: compare every accepted pixel against the oldest prediction,
  // then stall ready for a random gap.
  always @(posedge clk_i or negedge rst_ni) begin : px_monitor
    int unsigned rx_gap;
    int unsigned rx_burst;
    shaded_px_t  want;
    if (!rst_ni) begin
      pix_out_bus.ready <= 1'b0;
      rx_gap   = 0;
      rx_burst = 0;
    end else begin
      if (pix_out_bus.valid && pix_out_bus.ready) begin
        if (shaded_q.size() == 0) begin
          $display("%0t: unexpected pixel addr=%h argb=%h", $time,
                   pix_out_bus.pixel_address, pix_out_bus.pixel_color);
          fail_cnt++;
        end else begin
          want = shaded_q.pop_front();
          if (pix_out_bus.pixel_address !== want.addr) begin
            $display("%0t: pixel_address expected %h actual %h", $time,
                     want.addr, pix_out_bus.pixel_address);
            fail_cnt++;
          end
          if (pix_out_bus.pixel_color !== want.argb) begin
            $display("%0t: pixel_color expected %h actual %h (addr %h)", $time,
                     want.argb, pix_out_bus.pixel_color, want.addr);
            fail_cnt++;
          end
        end
        rx_gap = pick_gap(rx_burst);
      end
      pix_out_bus.ready <= !rx_hold && rx_gap == 0;
      if (rx_gap != 0) rx_gap--;
    end
  end

  // Watchdog: a stuck handshake or a lost result ends here.
  initial begin
    for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
  endtask

  // Program every register, mirror the values, then release the write enable.
  task automatic load_shape(input int x, input int y, input int w, input int h,
                            input int rad, input int fth, input logic [COLOR_W-1:0] argb);
    write_reg(REG_RECT_X,        CFG_DATA_W'(x & 32'h1FFF));
    write_reg(REG_RECT_Y,        CFG_DATA_W'(y & 32'h1FFF));
    write_reg(REG_RECT_W,        CFG_DATA_W'(w & 32'h1FFF));
    write_reg(REG_RECT_H,        CFG_DATA_W'(h & 32'h1FFF));
    write_reg(REG_CORNER_RADIUS, CFG_DATA_W'(rad & 32'h3FF));
    write_reg(REG_FEATHER_WIDTH, CFG_DATA_W'(fth & 32'h3FF));
    write_reg(REG_FILL_COLOR,    argb);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shape.rect_x        = POS_W'(x);
    shape.rect_y        = POS_W'(y);
    shape.rect_w        = POS_W'(w);
    shape.rect_h        = POS_W'(h);
    shape.corner_radius = RAD_W'(rad);
    shape.feather_width = RAD_W'(fth);
    shape.fill_color    = argb;
  endtask

  // Block until every request is taken and every predicted pixel has come back,
  // then let clipped requests still in the pipeline drain out.
  task automatic wait_idle();
    while (pending_px_q.size() != 0 || shaded_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_px(input int c, input int r);
    pending_px_q.push_back('{col: PIX_W'(c), row: PIX_W'(r)});
  endtask

  function automatic int pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 96);
    if (roll < 90) return $urandom_range(97, 4096);
    return ($urandom_range(0, 1) != 0) ? 1 : 4096;
  endfunction

  // One randomized shape plus a stream of at most max_tries pixels biased toward
  // its corners. Hands back how many pixels were queued.
  task automatic run_random_phase(input int phase_no, input int max_tries, output int sent);
    int          x, y, w, h, rad, fth, wmin, band, c, r, tries, kept;
    int unsigned roll;
    shaded_px_t  scratch;
    w    = pick_size();
    h    = pick_size();
    wmin = (w < h) ? w : h;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      x = int'($urandom_range(0, FB_W - 1)) - int'($urandom_range(0, (w < 64) ? w : 64));
      y = int'($urandom_range(0, FB_H - 1)) - int'($urandom_range(0, (h < 64) ? h : 64));
    end else begin
      x = int'($urandom_range(0, 8191)) - 4096;
      y = int'($urandom_range(0, 8191)) - 4096;
    end
    roll = $urandom_range(0, 99);
    if (roll < 20)      rad = 0;
    else if (roll < 60) rad = $urandom_range(1, (wmin / 2 > 1) ? wmin / 2 : 1);
    else if (roll < 80) rad = $urandom_range(wmin / 2, wmin + 8);   // corners overlap
    else if (roll < 95) rad = $urandom_range(0, 1023);
    else                rad = 1023;
    if (rad > 1023) rad = 1023;
    roll = $urandom_range(0, 99);
    if (roll < 25)      fth = 0;
    else if (roll < 75) fth = $urandom_range(1, 16);
    else if (roll < 95) fth = $urandom_range(17, 1023);
    else                fth = 1023;
    load_shape(x, y, w, h, rad, fth, $urandom);
    @(negedge clk_i);

    kept = 0;
    for (tries = 0; tries < max_tries && kept < PHASE_KEPT; tries++) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        // noise: anywhere in the field range, mostly clipped
        c = $urandom_range(0, 4095);
        r = $urandom_range(0, 4095);
      end else if (roll < 60) begin
        // near an edge, where corners and fade bands live
        band = rad + fth + 2;
        c = $urandom_range(0, ((band < w) ? band : w) - 1);
        r = $urandom_range(0, ((band < h) ? band : h) - 1);
        if ($urandom_range(0, 1) != 0) c = w - 1 - c;
        if ($urandom_range(0, 1) != 0) r = h - 1 - r;
      end else begin
        c = $urandom_range(0, w - 1);
        r = $urandom_range(0, h - 1);
      end
      if (c > 4095) c = 4095;
      if (r > 4095) r = 4095;
      queue_px(c, r);
      if (shade_pixel(shape, PIX_W'(c), PIX_W'(r), scratch)) kept++;
      // Once per run, hold the sender mid-phase until everything has come back.
      if (phase_no == 2 && tries == PHASE_TRIES / 4) wait_idle();
    end
    // Once per run, starve the output while a full phase of requests is queued.
    if (phase_no == 1) hold_req++;
    wait_idle();
    sent = tries;
  endtask

  initial begin : stimulus
    int sent_total;
    int phase_sent;
    int budget;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_RECT_X;
    cfg_wdata_i        = '0;
    shape              = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Registers at reset: zero-sized rectangle clips everything.
    queue_px(0, 0);
    queue_px(4095, 4095);
    wait_idle();

    // Corners of all four kinds, exact radius (fill), exact radius plus feather
    // (clear), fade band, interior, and requests just past width and height.
    load_shape(0, 0, 64, 48, 20, 5, 32'h80FF_8040);
    @(negedge clk_i);
    queue_px(0, 0);
    queue_px(8, 4);
    queue_px(5, 0);
    queue_px(4, 4);
    queue_px(63, 0);
    queue_px(0, 47);
    queue_px(63, 47);
    queue_px(32, 24);
    queue_px(64, 0);
    queue_px(0, 48);
    wait_idle();

    // Zero feather with radius larger than half the size, so corner squares
    // overlap; left edge off the framebuffer, bottom rows past its last line.
    load_shape(-5, 1000, 40, 30, 30, 0, 32'hFFFF_FFFF);
    @(negedge clk_i);
    queue_px(0, 0);
    queue_px(10, 5);
    queue_px(20, 15);
    queue_px(39, 23);
    queue_px(35, 2);
    queue_px(30, 29);
    wait_idle();

    // Largest radius and feather, highest address; the spare index must not
    // disturb any register.
    load_shape(FB_W - 1, FB_H - 1, 4096, 4096, 1023, 1023, 32'hFF12_3456);
    write_reg(CFG_IDX_SPARE, 32'hFFFF_FFFF);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    queue_px(0, 0);
    queue_px(1, 0);
    wait_idle();

    // Most negative origin and most positive row offset: fully off screen.
    load_shape(-4096, 4095, 4096, 4096, 0, 0, 32'h0000_0000);
    @(negedge clk_i);
    queue_px(4095, 0);
    wait_idle();

    sent_total = 0;
    for (int p = 0; p < MAX_PHASES && sent_total < RAND_ITEMS; p++) begin
      budget = RAND_ITEMS - sent_total;
      if (budget > PHASE_TRIES) budget = PHASE_TRIES;
      run_random_phase(p, budget, phase_sent);
      sent_total += phase_sent;
    end

    wait_idle();
    if (fail_cnt == 0 && shaded_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: rounded_rect_pixel_shader.f
hw/rtl/rrs_pkg.sv
hw/rtl/rrs_pix_in_if.sv
hw/rtl/rrs_pix_out_if.sv
hw/rtl/rrs_front.sv
hw/rtl/rrs_sqrt.sv
hw/rtl/rrs_fade.sv
hw/rtl/rounded_rect_pixel_shader.sv
tb/sv/rounded_rect_pixel_shader_tb.sv
